[rtl/ntc_ratio_to_temperature_defines.svh]
// ----------------------------------------------------------------------------
// NTC ratio to temperature: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef NTC_RATIO_TO_TEMPERATURE_DEFINES_SVH
`define NTC_RATIO_TO_TEMPERATURE_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define NTCR_ASSERT_HOLD(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cond)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define NTCR_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

[rtl/ntcr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NTC ratio to temperature: package
// Fixed widths, polynomial and Beta constants, and the control bundle.
// ----------------------------------------------------------------------------
package ntcr_pkg;

  localparam int unsigned VIN_W    = 16;
  localparam int unsigned RATIO_W  = 48;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned X_W      = 32;
  localparam int unsigned ACC_W    = 34;
  localparam int unsigned PROD_W   = ACC_W + X_W;
  localparam int unsigned FRAC_SH  = 30;
  localparam int unsigned LNR_W    = 36;
  localparam int unsigned MAG_W    = 35;
  localparam int unsigned RCP_W    = 54;
  localparam int unsigned RCP_LO_W = 32;
  localparam int unsigned RCP_SH   = 45;
  localparam int unsigned RPROD_W  = MAG_W + RCP_W;
  localparam int unsigned Q2_W     = RPROD_W - RCP_SH;
  localparam int unsigned IT_W     = 46;
  localparam int unsigned DIV_W    = 43;
  localparam int unsigned SAT_EXP  = 37;
  localparam int unsigned TEMP_W   = 16;
  localparam int unsigned HORNER_N = 4;

  // ceil(2^65 / 3380): (m * BETA_RCP) >> 45 equals floor(m * 2^20 / 3380)
  // exactly for every m below 2^35
  localparam logic [RCP_W-1:0] BETA_RCP =
    RCP_W'(((64'd1 << 63) + 64'd844) / 64'd845);

  localparam logic signed [ACC_W-1:0] COEF0 =
    ACC_W'((-64'sd17417939 * 64'sd1073741824) / 64'sd10000000);
  localparam logic signed [ACC_W-1:0] COEF1 =
    ACC_W'((64'sd28212026 * 64'sd1073741824) / 64'sd10000000);
  localparam logic signed [ACC_W-1:0] COEF2 =
    ACC_W'((-64'sd14699568 * 64'sd1073741824) / 64'sd10000000);
  localparam logic signed [ACC_W-1:0] COEF3 =
    ACC_W'((64'sd44717955 * 64'sd1073741824) / 64'sd100000000);
  localparam logic signed [ACC_W-1:0] COEF4 =
    ACC_W'((-64'sd56570851 * 64'sd1073741824) / 64'sd1000000000);
  localparam logic signed [ACC_W-1:0] LN2_Q30 =
    ACC_W'((64'sd69314718 * 64'sd1073741824) / 64'sd100000000);
  localparam logic signed [IT_W-1:0] INV_T0_Q50 =
    IT_W'((64'sd20 <<< 50) / 64'sd5963);
  localparam logic signed [PROD_W-1:0] RND_Q30 =
    PROD_W'((64'sd1 <<< FRAC_SH) - 64'sd1);

  // Coefficient added after each Horner product, in order
  localparam logic signed [ACC_W-1:0] HORNER_C [HORNER_N] = '{COEF3, COEF2, COEF1, COEF0};

  typedef struct packed {
    logic vld;
    logic zero;
  } ntcr_ctl_t;

endpackage

[rtl/ntcr_div_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NTC ratio to temperature: restoring division step
// Shift in one dividend bit, trial-subtract the divisor, emit one quotient bit.
// ----------------------------------------------------------------------------
module ntcr_div_stage #(
  parameter int unsigned RW = 16,
  parameter int unsigned NW = 48,
  parameter int unsigned PW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [PW-1:0] pay_i,
  input  logic [RW-1:0] rem_i,
  input  logic [NW-1:0] nq_i,
  input  logic [RW-1:0] div_i,
  output logic          vld_o,
  output logic [PW-1:0] pay_o,
  output logic [RW-1:0] rem_o,
  output logic [NW-1:0] nq_o,
  output logic [RW-1:0] div_o
);

  logic [RW:0]   trial, diff;
  logic          ge;
  logic          vld_q;
  logic [PW-1:0] pay_q;
  logic [RW-1:0] rem_q, div_q;
  logic [NW-1:0] nq_q;

  assign trial = {rem_i, nq_i[NW-1]};
  assign diff  = trial - {1'b0, div_i};
  assign ge    = ~diff[RW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= ge ? diff[RW-1:0] : trial[RW-1:0];
      nq_q  <= {nq_i[NW-2:0], ge};
      div_q <= div_i;
      pay_q <= pay_i;
    end
  end

  assign vld_o = vld_q;
  assign pay_o = pay_q;
  assign rem_o = rem_q;
  assign nq_o  = nq_q;
  assign div_o = div_q;

endmodule

[rtl/ntcr_div_chain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NTC ratio to temperature: division row
// One division step per quotient bit, each handing its partial result on.
// ----------------------------------------------------------------------------
module ntcr_div_chain #(
  parameter int unsigned RW = 16,
  parameter int unsigned NW = 48,
  parameter int unsigned PW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [PW-1:0] pay_i,
  input  logic [RW-1:0] rem_i,
  input  logic [NW-1:0] nq_i,
  input  logic [RW-1:0] div_i,
  output logic          vld_o,
  output logic [PW-1:0] pay_o,
  output logic [NW-1:0] quo_o
);

  logic          vld_a [NW+1];
  logic [PW-1:0] pay_a [NW+1];
  logic [RW-1:0] rem_a [NW+1];
  logic [NW-1:0] nq_a  [NW+1];
  logic [RW-1:0] div_a [NW+1];

  assign vld_a[0] = vld_i;
  assign pay_a[0] = pay_i;
  assign rem_a[0] = rem_i;
  assign nq_a[0]  = nq_i;
  assign div_a[0] = div_i;

  for (genvar k = 0; k < NW; k++) begin : g_step
    ntcr_div_stage #(.RW(RW), .NW(NW), .PW(PW)) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .vld_i  (vld_a[k]),
      .pay_i  (pay_a[k]),
      .rem_i  (rem_a[k]),
      .nq_i   (nq_a[k]),
      .div_i  (div_a[k]),
      .vld_o  (vld_a[k+1]),
      .pay_o  (pay_a[k+1]),
      .rem_o  (rem_a[k+1]),
      .nq_o   (nq_a[k+1]),
      .div_o  (div_a[k+1])
    );
  end

  assign vld_o = vld_a[NW];
  assign pay_o = pay_a[NW];
  assign quo_o = nq_a[NW];

endmodule

[rtl/ntcr_log_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NTC ratio to temperature: natural log pipeline
// Leading one, normalize to [1,2), Horner polynomial, add exponent times ln2.
// ----------------------------------------------------------------------------
module ntcr_log_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  ntcr_pkg::ntcr_ctl_t                 ctl_i,
  input  logic [ntcr_pkg::RATIO_W-1:0]        ratio_i,
  output ntcr_pkg::ntcr_ctl_t                 ctl_o,
  output logic signed [ntcr_pkg::LNR_W-1:0]   lnr_o
);

  localparam int unsigned N = ntcr_pkg::HORNER_N;

  // leading one
  logic [ntcr_pkg::POS_W-1:0]   pos_d, pos1_q;
  logic [ntcr_pkg::RATIO_W-1:0] ratio1_q, shv;
  ntcr_pkg::ntcr_ctl_t          ctl1_q, ctl2_q, ctl_ln_q;
  // normalized mantissa and exponent
  logic signed [ntcr_pkg::X_W-1:0]   x2_q;
  logic signed [ntcr_pkg::POS_W:0]   e2_q;
  // Horner steps: product stage, then add stage
  logic signed [ntcr_pkg::ACC_W-1:0]  acc_in [N];
  logic signed [ntcr_pkg::X_W-1:0]    x_in   [N];
  logic signed [ntcr_pkg::POS_W:0]    e_in   [N];
  ntcr_pkg::ntcr_ctl_t                ctl_in [N];
  logic signed [ntcr_pkg::PROD_W-1:0] prod_q [N];
  logic signed [ntcr_pkg::X_W-1:0]    xp_q   [N];
  logic signed [ntcr_pkg::POS_W:0]    ep_q   [N];
  ntcr_pkg::ntcr_ctl_t                ctlp_q [N];
  logic signed [ntcr_pkg::PROD_W-1:0] rnd    [N];
  logic signed [ntcr_pkg::ACC_W-1:0]  acc_q  [N];
  logic signed [ntcr_pkg::X_W-1:0]    xa_q   [N];
  logic signed [ntcr_pkg::POS_W:0]    ea_q   [N];
  ntcr_pkg::ntcr_ctl_t                ctla_q [N];
  logic signed [ntcr_pkg::LNR_W-1:0]  lnr_q;

  always_comb begin
    pos_d = '0;
    for (int i = 0; i < ntcr_pkg::RATIO_W; i++) begin
      if (ratio_i[i]) begin
        pos_d = ntcr_pkg::POS_W'(i);
      end
    end
  end

  always_comb begin
    if (pos1_q >= ntcr_pkg::POS_W'(ntcr_pkg::FRAC_SH)) begin
      shv = ratio1_q >> (pos1_q - ntcr_pkg::POS_W'(ntcr_pkg::FRAC_SH));
    end else begin
      shv = ratio1_q << (ntcr_pkg::POS_W'(ntcr_pkg::FRAC_SH) - pos1_q);
    end
  end

  always_comb begin
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        acc_in[k] = ntcr_pkg::COEF4;
        x_in[k]   = x2_q;
        e_in[k]   = e2_q;
        ctl_in[k] = ctl2_q;
      end else begin
        acc_in[k] = acc_q[k-1];
        x_in[k]   = xa_q[k-1];
        e_in[k]   = ea_q[k-1];
        ctl_in[k] = ctla_q[k-1];
      end
      // truncate the product toward zero
      rnd[k] = prod_q[k][ntcr_pkg::PROD_W-1] ? (prod_q[k] + ntcr_pkg::RND_Q30) : prod_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q   <= '0;
      ctl2_q   <= '0;
      ctl_ln_q <= '0;
      for (int k = 0; k < N; k++) begin
        ctlp_q[k] <= '0;
        ctla_q[k] <= '0;
      end
    end else if (en_i) begin
      ctl1_q   <= ctl_i;
      ctl2_q   <= ctl1_q;
      ctl_ln_q <= ctla_q[N-1];
      for (int k = 0; k < N; k++) begin
        ctlp_q[k] <= ctl_in[k];
        ctla_q[k] <= ctlp_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ratio1_q <= ratio_i;
      pos1_q   <= pos_d;
      x2_q     <= {1'b0, shv[ntcr_pkg::X_W-2:0]};
      e2_q     <= $signed({1'b0, pos1_q}) - (ntcr_pkg::POS_W+1)'(32);
      for (int k = 0; k < N; k++) begin
        prod_q[k] <= acc_in[k] * x_in[k];
        xp_q[k]   <= x_in[k];
        ep_q[k]   <= e_in[k];
        acc_q[k]  <= ntcr_pkg::ACC_W'(rnd[k] >>> ntcr_pkg::FRAC_SH) + ntcr_pkg::HORNER_C[k];
        xa_q[k]   <= xp_q[k];
        ea_q[k]   <= ep_q[k];
      end
      lnr_q <= ntcr_pkg::LNR_W'(acc_q[N-1])
             + ntcr_pkg::LNR_W'(ea_q[N-1]) * ntcr_pkg::LNR_W'(ntcr_pkg::LN2_Q30);
    end
  end

  assign ctl_o = ctl_ln_q;
  assign lnr_o = lnr_q;

endmodule

[rtl/ntc_ratio_to_temperature.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NTC ratio to temperature
// Converts a reference/thermistor reading pair to degrees C with the Beta
// equation; log by polynomial, variable divisions by rows of restoring steps,
// the division by Beta by a reciprocal multiply.
// ----------------------------------------------------------------------------
//
//  channel   | direction | payload
//  ----------+-----------+-------------------------------------------------
//  s_axis    | in        | tdata[15:0] ref_voltage, [31:16] ntc_voltage
//  m_axis    | out       | tdata[15:0] temperature (signed), tuser invalid
//  cfg       | in        | cfg_wdata_i temp_offset (signed), write on cfg_we_i
//
// One request enters per cycle while the pipeline is not stalled, and the
// pipeline holds no feedback, so the rate is one pair per clock. The path is
// a 48-step ratio divider, an 11-stage log, a two-stage reciprocal multiply
// by 1/Beta, two stages for 1/T, an (OUT_FRAC_BITS+13)-step kelvin divider
// and the output register. Reset clears the valid bits and the offset. The
// whole pipeline advances together; it stalls only while a finished result
// sits in the output register and m_axis_tready is low.
//
`include "ntc_ratio_to_temperature_defines.svh"

module ntc_ratio_to_temperature #(
  parameter int unsigned OUT_FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,    // temp_offset
  // reading pairs
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] ref_voltage, [31:16] ntc_voltage
  // temperatures
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] temperature
  output logic        m_axis_tuser    // [0] invalid
);

  // Kelvin quotient width: wide enough that any result that fits 16 bits is exact
  localparam int unsigned KW    = OUT_FRAC_BITS + 13;
  localparam int unsigned RES_W = KW + 2;
  localparam longint KQ_L = ((64'sd27315 <<< OUT_FRAC_BITS) + 64'sd50) / 64'sd100;
  localparam logic signed [RES_W-1:0] KELVIN_Q = RES_W'(KQ_L);
  localparam logic signed [RES_W-1:0] TMAX = RES_W'(32767);
  localparam logic signed [RES_W-1:0] TMIN = -RES_W'(32768);
  localparam logic signed [ntcr_pkg::IT_W-1:0] SAT_LIM =
    ntcr_pkg::IT_W'(64'sd1 <<< ntcr_pkg::SAT_EXP);
  localparam logic [ntcr_pkg::DIV_W-1:0] REM3_INIT =
    ntcr_pkg::DIV_W'(64'd1 << ntcr_pkg::SAT_EXP);
  localparam int unsigned MHI_W = ntcr_pkg::MAG_W - ntcr_pkg::RCP_LO_W;
  localparam int unsigned RHI_W = ntcr_pkg::RCP_W - ntcr_pkg::RCP_LO_W;
  localparam logic [ntcr_pkg::RCP_LO_W-1:0] RCP_LO =
    ntcr_pkg::BETA_RCP[ntcr_pkg::RCP_LO_W-1:0];
  localparam logic [RHI_W-1:0] RCP_HI =
    ntcr_pkg::BETA_RCP[ntcr_pkg::RCP_W-1:ntcr_pkg::RCP_LO_W];

  logic en;

  // offset register
  logic signed [ntcr_pkg::TEMP_W-1:0] temp_offset_q;

  // input fields
  logic [ntcr_pkg::VIN_W-1:0] ref_voltage, ntc_voltage;

  // ratio divider
  logic                          c1_vld;
  logic [0:0]                    c1_pay;
  logic [ntcr_pkg::RATIO_W-1:0]  c1_quo;
  ntcr_pkg::ntcr_ctl_t           log_ctl_in, log_ctl;
  logic signed [ntcr_pkg::LNR_W-1:0] lnr;

  // divide ln by Beta: partial products, then sum and take the quotient
  logic                               lnr_neg;
  logic [ntcr_pkg::MAG_W-1:0]         lnr_mag;
  logic [ntcr_pkg::RCP_LO_W-1:0]      mag_lo;
  logic [MHI_W-1:0]                   mag_hi;
  logic                               rp_vld_q;
  logic [1:0]                         rp_pay_q;   // {zero, negative}
  logic [2*ntcr_pkg::RCP_LO_W-1:0]    pll_q;
  logic [ntcr_pkg::RCP_W-1:0]         plh_q;
  logic [ntcr_pkg::RCP_W+MHI_W-1:0]   ph_q;
  logic [ntcr_pkg::RPROD_W-1:0]       rprod;
  logic                               c2_vld_q;
  logic [1:0]                         c2_pay_q;   // {zero, negative}
  logic [ntcr_pkg::Q2_W-1:0]          c2_quo_q;
  logic signed [ntcr_pkg::IT_W-1:0]   q2s, inv_t_d;

  // 1/T and saturation check
  logic                              iv_vld_q, iv_zero_q;
  logic signed [ntcr_pkg::IT_W-1:0]  inv_t_q;
  logic                              st_vld_q, st_zero_q, st_sat_q;
  logic [ntcr_pkg::DIV_W-1:0]        div3_q;

  // kelvin divider
  logic          c3_vld;
  logic [1:0]    c3_pay;   // {zero, saturated}
  logic [KW-1:0] c3_quo;

  // output register
  logic signed [RES_W-1:0]            res;
  logic signed [ntcr_pkg::TEMP_W-1:0] temp_d, temp_q;
  logic                               inv_d, inv_q, m_vld_q;

  // Advance everything unless a result is waiting and not taken
  assign en            = !m_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  assign ref_voltage = s_axis_tdata[15:0];
  assign ntc_voltage = s_axis_tdata[31:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_offset_q <= '0;
    end else if (cfg_we_i) begin
      temp_offset_q <= cfg_wdata_i;
    end
  end

  // ratio = (ntc << 32) / ref, one quotient bit per step
  ntcr_div_chain #(.RW(ntcr_pkg::VIN_W), .NW(ntcr_pkg::RATIO_W), .PW(1)) u_ratio_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_axis_tvalid),
    .pay_i  ((ref_voltage == '0) || (ntc_voltage == '0)),
    .rem_i  ('0),
    .nq_i   ({ntc_voltage, {(ntcr_pkg::RATIO_W - ntcr_pkg::VIN_W){1'b0}}}),
    .div_i  (ref_voltage),
    .vld_o  (c1_vld),
    .pay_o  (c1_pay),
    .quo_o  (c1_quo)
  );

  assign log_ctl_in.vld  = c1_vld;
  assign log_ctl_in.zero = c1_pay[0];

  ntcr_log_unit u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .ctl_i   (log_ctl_in),
    .ratio_i (c1_quo),
    .ctl_o   (log_ctl),
    .lnr_o   (lnr)
  );

  // ln(r) * 2^20 / Beta on the magnitude; the sign goes back on after
  assign lnr_neg = lnr[ntcr_pkg::LNR_W-1];
  assign lnr_mag = ntcr_pkg::MAG_W'(lnr_neg ? -lnr : lnr);
  assign mag_lo  = lnr_mag[ntcr_pkg::RCP_LO_W-1:0];
  assign mag_hi  = lnr_mag[ntcr_pkg::MAG_W-1:ntcr_pkg::RCP_LO_W];

  // Split the multiply by the reciprocal into low-by-low, low-by-high and high-by-whole partial products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_vld_q <= 1'b0;
      c2_vld_q <= 1'b0;
    end else if (en) begin
      rp_vld_q <= log_ctl.vld;
      c2_vld_q <= rp_vld_q;
    end
  end

  assign rprod = ntcr_pkg::RPROD_W'({(ntcr_pkg::RCP_W + MHI_W + 1)'(plh_q)
                                     + (ntcr_pkg::RCP_W + MHI_W + 1)'(ph_q),
                                     {ntcr_pkg::RCP_LO_W{1'b0}}})
               + ntcr_pkg::RPROD_W'(pll_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      pll_q    <= mag_lo * RCP_LO;
      plh_q    <= mag_lo * RCP_HI;
      ph_q     <= mag_hi * ntcr_pkg::BETA_RCP;
      rp_pay_q <= {log_ctl.zero, lnr_neg};
      c2_quo_q <= rprod[ntcr_pkg::RPROD_W-1:ntcr_pkg::RCP_SH];
      c2_pay_q <= rp_pay_q;
    end
  end

  assign q2s     = $signed(ntcr_pkg::IT_W'(c2_quo_q));
  assign inv_t_d = ntcr_pkg::INV_T0_Q50 + (c2_pay_q[0] ? -q2s : q2s);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_vld_q <= 1'b0;
      st_vld_q <= 1'b0;
    end else if (en) begin
      iv_vld_q <= c2_vld_q;
      st_vld_q <= iv_vld_q;
    end
  end

  // Flag 1/T at or below 2^37: that covers non-positive 1/T and every
  // kelvin value too large for the kelvin quotient
  always_ff @(posedge clk_i) begin
    if (en) begin
      inv_t_q   <= inv_t_d;
      iv_zero_q <= c2_pay_q[1];
      st_zero_q <= iv_zero_q;
      st_sat_q  <= (inv_t_q <= SAT_LIM);
      div3_q    <= inv_t_q[ntcr_pkg::DIV_W-1:0];
    end
  end

  // kelvin = 2^(50+OUT_FRAC_BITS) / (1/T); dividend top part starts in the remainder
  ntcr_div_chain #(.RW(ntcr_pkg::DIV_W), .NW(KW), .PW(2)) u_kelvin_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (st_vld_q),
    .pay_i  ({st_zero_q, st_sat_q}),
    .rem_i  (REM3_INIT),
    .nq_i   ('0),
    .div_i  (div3_q),
    .vld_o  (c3_vld),
    .pay_o  (c3_pay),
    .quo_o  (c3_quo)
  );

  // Celsius, minus offset, then clamp to 16 bits; a zero reading gives 0, flagged invalid
  assign res = $signed({2'b00, c3_quo}) - KELVIN_Q - RES_W'(temp_offset_q);

  always_comb begin
    temp_d = res[ntcr_pkg::TEMP_W-1:0];
    inv_d  = 1'b0;
    if (c3_pay[1]) begin
      temp_d = '0;
      inv_d  = 1'b1;
    end else if (c3_pay[0] || (res > TMAX)) begin
      temp_d = 16'sh7FFF;
      inv_d  = 1'b1;
    end else if (res < TMIN) begin
      temp_d = 16'sh8000;
      inv_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (en) begin
      m_vld_q <= c3_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      temp_q <= temp_d;
      inv_q  <= inv_d;
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = temp_q;
  assign m_axis_tuser  = inv_q;

  `NTCR_ASSERT_NEXT(a_zero_flagged, en && c3_vld && c3_pay[1], m_axis_tvalid && (m_axis_tdata == 16'h0000) && m_axis_tuser, "zero reading not reported as flagged zero")
  `NTCR_ASSERT_NEXT(a_sat_high, en && c3_vld && !c3_pay[1] && c3_pay[0], m_axis_tvalid && (m_axis_tdata == 16'h7FFF) && m_axis_tuser, "small 1/T not saturated high")
  `NTCR_ASSERT_HOLD(a_stall_cause, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without a waiting result")

endmodule
